>>> hw/rtl/crc16bs_pkg.sv
// ============================================================================
// crc16bs_pkg: shared types, constants and byte fold for the crc16 unit
// Holds the request record, the reset and seed constants and the byte-wise
// update of the reflected 0xA001 polynomial over the two 8-bit halves.
// ============================================================================
package crc16bs_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W  = 16;

    localparam logic [CRC_W-1:0]  SEED_RESET  = 16'hFFFF;
    localparam logic [BYTE_W-1:0] HALF_RESET  = 8'hFF;
    localparam logic [CRC_W-1:0]  EMPTY_VALUE = 16'h0001;

    localparam logic [BYTE_W-1:0] POLY_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] HIGH_BIT  = 8'h80;

    // one input request as held in the input stage
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first_byte;
        logic              last_byte;
        logic              empty_msg;
    } crc16bs_req_t;

    // running value split into its two halves
    typedef struct packed {
        logic [BYTE_W-1:0] high;
        logic [BYTE_W-1:0] low;
    } crc16bs_halves_t;

    // fold one message byte into the halves, parity-trick form
    function automatic crc16bs_halves_t crc16bs_fold(
        input logic [BYTE_W-1:0] b,
        input crc16bs_halves_t   cur
    );
        logic [BYTE_W-1:0] s;
        logic [BYTE_W-1:0] h;
        logic [BYTE_W-1:0] l;
        logic              par;
        crc16bs_halves_t   res;
        s = b ^ cur.high;
        h = cur.low;
        if (s[1])
        begin
            h = h - HIGH_BIT;
        end
        if (s[0])
        begin
            h = h ^ POLY_MASK;
        end
        l = s >> 1;
        l = l ^ s;
        l = l >> 1;
        s = s ^ l;
        if (s[3])
        begin
            s = s - 8'd1;
        end
        if (s[6])
        begin
            s = s - 8'd1;
        end
        par = s[0];
        if (par)
        begin
            l = l ^ POLY_MASK;
        end
        h = h ^ {{(BYTE_W-1){1'b0}}, par};
        res.high = h;
        res.low  = l;
        return res;
    endfunction

endpackage

>>> hw/rtl/crc16bs_core.sv
// ============================================================================
// crc16bs_core: running crc state, seed register and byte update
// Loads the halves from the seed on a first byte, folds the byte in and
// offers the value for the result register; empty messages leave state.
// ============================================================================
module crc16bs_core
    import crc16bs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              seed_we,
    input  logic [CRC_W-1:0]  seed_wdata,
    input  logic              step,
    input  crc16bs_req_t      req,
    output logic [CRC_W-1:0]  result_word
);

    logic [CRC_W-1:0] seed_reg;
    crc16bs_halves_t  halves_reg;
    crc16bs_halves_t  start_halves;
    crc16bs_halves_t  halves_next;

    // seed register, written whenever the enable is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
        end
        else if (seed_we)
        begin
            seed_reg <= seed_wdata;
        end
    end

    // start point and byte fold
    always_comb
    begin
        if (req.first_byte)
        begin
            start_halves.high = seed_reg[CRC_W-1:BYTE_W];
            start_halves.low  = seed_reg[BYTE_W-1:0];
        end
        else
        begin
            start_halves = halves_reg;
        end
        halves_next = crc16bs_fold(req.data_byte, start_halves);
    end

    // running halves update on every non-empty request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halves_reg.high <= HALF_RESET;
            halves_reg.low  <= HALF_RESET;
        end
        else if (step && !req.empty_msg)
        begin
            halves_reg <= halves_next;
        end
    end

    // value offered to the result register
    assign result_word = req.empty_msg ? EMPTY_VALUE : {halves_next.high, halves_next.low};

    // empty request keeps the running value
    a_empty_keeps_state: assert property (
        @(posedge clk) disable iff (!rst_n)
        step && req.empty_msg |=> $stable(halves_reg)
    ) else $error("running crc changed on an empty message");

    // a folded request leaves the offered value in the state
    a_state_follows_fold: assert property (
        @(posedge clk) disable iff (!rst_n)
        step && !req.empty_msg |=> {halves_reg.high, halves_reg.low} == $past(result_word)
    ) else $error("running crc does not match the folded value");

    // idle cycles keep the running value
    a_idle_keeps_state: assert property (
        @(posedge clk) disable iff (!rst_n)
        !step |=> $stable(halves_reg)
    ) else $error("running crc changed without a request");

endmodule

>>> hw/rtl/crc16bs_out_reg.sv
// ============================================================================
// crc16bs_out_reg: result register with valid/ready output handshake
// Captures a finished crc value and holds it until the consumer takes it.
// ============================================================================
module crc16bs_out_reg
    import crc16bs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [CRC_W-1:0] load_word,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [CRC_W-1:0] crc_value
);

    logic             valid_reg;
    logic [CRC_W-1:0] word_reg;

    // valid flag: set on load, cleared when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= load_word;
        end
    end

    assign out_valid = valid_reg;
    assign crc_value = word_reg;

    // a held result is never overwritten
    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |-> !load
    ) else $error("result register overwritten while stalled");

endmodule

>>> hw/rtl/crc16_bytewise_seeded_unit.sv
// ============================================================================
// crc16_bytewise_seeded_unit: byte-serial seeded crc-16 (reflected 0xA001)
// One message byte per request; a result request ends the message with
// the 16-bit value, an empty message returns the value 1.
// ============================================================================
//
//  channel   handshake              payload
//  -------   --------------------   -------------------------------------------
//  in        in_valid / in_ready    data_byte, first_byte, last_byte, empty_msg
//  out       out_valid / out_ready  crc_value
//  seed      seed_we                seed_wdata
//
//  one request per cycle unless a result request waits on a stalled output;
//  results pass the input register, then fold logic into the result register
//  the running halves are updated as a request leaves the input register,
//  so the next byte sees them in the following cycle
//  reset: seed and running halves 0xFFFF, both stages empty
//  a stalled result blocks only requests that produce a result; other bytes
//  keep flowing past it
//
module crc16_bytewise_seeded_unit
    import crc16bs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              seed_we,
    input  logic [CRC_W-1:0]  seed_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              first_byte,
    input  logic              last_byte,
    input  logic              empty_msg,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CRC_W-1:0]  crc_value
);

    logic             s1_valid_reg;
    crc16bs_req_t     s1_req_reg;
    logic             s1_result;
    logic             s1_fire;
    logic             out_free;
    logic             in_fire;
    logic [CRC_W-1:0] result_word;

    // input stage advance control
    assign out_free  = !out_valid || out_ready;
    assign s1_result = s1_req_reg.empty_msg || s1_req_reg.last_byte;
    assign s1_fire   = s1_valid_reg && (!s1_result || out_free);
    assign in_ready  = !s1_valid_reg || s1_fire;
    assign in_fire   = in_valid && in_ready;

    // input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_req_reg.data_byte  <= data_byte;
            s1_req_reg.first_byte <= first_byte;
            s1_req_reg.last_byte  <= last_byte;
            s1_req_reg.empty_msg  <= empty_msg;
        end
    end

    // crc state and byte update
    crc16bs_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .seed_we     (seed_we),
        .seed_wdata  (seed_wdata),
        .step        (s1_fire),
        .req         (s1_req_reg),
        .result_word (result_word)
    );

    // result register
    crc16bs_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_fire && s1_result),
        .load_word (result_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .crc_value (crc_value)
    );

    // empty message yields the value 1 next cycle
    a_empty_value: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_fire && s1_req_reg.empty_msg |=> out_valid && crc_value == EMPTY_VALUE
    ) else $error("empty message did not produce the value 1");

    // a byte without result leaves the output side alone
    a_no_spurious_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_fire && !s1_result |=> out_valid == $past(out_valid && !out_ready)
    ) else $error("result appeared for a byte that ends no message");

    // back pressure only comes from a held request
    a_ready_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && s1_result && out_valid && !out_ready
    ) else $error("input stalled without cause");

endmodule
